// ----- sv/lpp_pkg.sv -----
`default_nettype none
package lpp_pkg;

   localparam int PW       = 24;
   localparam int RW       = 16;
   localparam int TW       = 21;
   localparam int FW       = 20;
   localparam int PXW      = 20;
   localparam int MDW      = 24;
   localparam int ROT_FRAC = 14;
   localparam int CW       = 28;
   localparam int AW       = ROT_FRAC + CW;
   localparam int PRW      = 48;
   localparam int NW       = 52;
   localparam int DW       = 32;
   localparam int QB       = PXW - 1;
   localparam int MW       = DW + QB;
   localparam int DIV_LAT  = QB + 1;
   localparam int TOTAL    = 4 + DIV_LAT + 1;
   localparam int RIW      = 3;
   localparam int CSRW     = 63;

   typedef enum logic [RIW-1:0] {
      REG_ROT_X       = 3'd0,
      REG_ROT_Y       = 3'd1,
      REG_ROT_Z       = 3'd2,
      REG_TRANSLATION = 3'd3,
      REG_FOCAL       = 3'd4,
      REG_PRINCIPAL   = 3'd5,
      REG_MIN_DEPTH   = 3'd6
   } reg_index_type;

   localparam logic [3*RW-1:0] ROT_X_RST = 48'h0000_0000_4000;
   localparam logic [3*RW-1:0] ROT_Y_RST = 48'h0000_4000_0000;
   localparam logic [3*RW-1:0] ROT_Z_RST = 48'h4000_0000_0000;
   localparam logic [3*TW-1:0] TRANS_RST = '0;
   localparam logic [2*FW-1:0] FOCAL_RST = 40'h20_0002_0000;
   localparam logic [2*FW-1:0] PRINC_RST = '0;
   localparam logic [MDW-1:0]  MIN_DEPTH_RST = 24'd6554;

   typedef struct packed {
      logic [2:0][2:0][RW-1:0] rot;
      logic [2:0][TW-1:0]      trans;
      logic [1:0][FW-1:0]      focal;
      logic [1:0][FW-1:0]      princ;
      logic [MDW-1:0]          min_depth;
   } cfg_type;

   typedef struct packed {
      logic          front;
      logic [PW-1:0] cam_x;
      logic [PW-1:0] cam_y;
      logic [PW-1:0] cam_z;
   } side_type;

   function automatic logic [PW-1:0] sat_cam(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] hi;
      logic signed [CW-1:0] lo;
      hi = {{(CW-PW+1){1'b0}}, {(PW-1){1'b1}}};
      lo = {{(CW-PW+1){1'b1}}, {(PW-1){1'b0}}};
      if (v > hi) begin
         return hi[PW-1:0];
      end else if (v < lo) begin
         return lo[PW-1:0];
      end
      return v[PW-1:0];
   endfunction

   function automatic logic [PXW-1:0] fmt_pixel(input logic [QB-1:0] q, input logic ovf,
                                                input logic neg);
      logic [PXW-1:0] mag;
      mag = {1'b0, q};
      if (ovf) begin
         return neg ? {1'b1, {(PXW-1){1'b0}}} : {1'b0, {(PXW-1){1'b1}}};
      end
      return neg ? ~mag : mag;
   endfunction

endpackage
`default_nettype wire

// ----- sv/lpp_if.sv -----
`default_nettype none
interface lpp_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [lpp_pkg::PW-1:0]   point_x;
   logic signed [lpp_pkg::PW-1:0]   point_y;
   logic signed [lpp_pkg::PW-1:0]   point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            in_front;
   logic signed [lpp_pkg::PW-1:0]   cam_x;
   logic signed [lpp_pkg::PW-1:0]   cam_y;
   logic signed [lpp_pkg::PW-1:0]   cam_z;
   logic signed [lpp_pkg::PXW-1:0]  pixel_u;
   logic signed [lpp_pkg::PXW-1:0]  pixel_v;

   modport source (output valid, in_front, cam_x, cam_y, cam_z, pixel_u, pixel_v,
                   input ready);
   modport sink   (input valid, in_front, cam_x, cam_y, cam_z, pixel_u, pixel_v,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/lpp_transform.sv -----
`default_nettype none
module lpp_transform (
   input  logic                                  clock,
   input  logic                                  en,
   input  lpp_pkg::cfg_type                      cfg,
   input  logic signed [lpp_pkg::PW-1:0]         point_x,
   input  logic signed [lpp_pkg::PW-1:0]         point_y,
   input  logic signed [lpp_pkg::PW-1:0]         point_z,
   output logic [2:0][lpp_pkg::CW-1:0]           cam
);
   import lpp_pkg::*;

   logic signed [PW-1:0] pt [3];
   logic signed [AW-1:0] prod_in [3][3];
   logic signed [AW-1:0] prod_ff [3][3];
   logic signed [AW-1:0] tsh_in [3];
   logic signed [AW-1:0] tsh_ff [3];
   logic signed [AW-1:0] acc [3];
   logic [2:0][CW-1:0]   cam_in;
   logic [2:0][CW-1:0]   cam_ff;

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;

   // stage 1: rotation products and shifted translation
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(cfg.rot[r][c]) * pt[c];
         end
         tsh_in[r] = AW'($signed(cfg.trans[r])) <<< ROT_FRAC;
      end
   end

   // stage 2: sum and round to q.16
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + tsh_ff[r]
                  + AW'(1 << (ROT_FRAC - 1));
         cam_in[r] = acc[r][AW-1:ROT_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         tsh_ff  <= tsh_in;
         cam_ff  <= cam_in;
      end
   end

   assign cam = cam_ff;
endmodule
`default_nettype wire

// ----- sv/lpp_project.sv -----
`default_nettype none
module lpp_project (
   input  logic                          clock,
   input  logic                          en,
   input  lpp_pkg::cfg_type              cfg,
   input  logic [2:0][lpp_pkg::CW-1:0]   cam,
   output logic [lpp_pkg::MW-1:0]        m_u,
   output logic [lpp_pkg::MW-1:0]        m_v,
   output logic                          neg_u,
   output logic                          neg_v,
   output logic [lpp_pkg::DW-1:0]        den,
   output lpp_pkg::side_type             side
);
   import lpp_pkg::*;

   logic signed [PRW-1:0] fa_in [2];
   logic signed [PRW-1:0] fa_ff [2];
   logic signed [PRW-1:0] cz_in [2];
   logic signed [PRW-1:0] cz_ff [2];
   logic signed [CW-1:0]  z_ff;
   side_type              side_a_in;
   side_type              side_a_ff;
   side_type              side_b_ff;
   logic signed [NW-1:0]  num [2];
   logic [MW-1:0]         m_in [2];
   logic [MW-1:0]         m_ff [2];
   logic [1:0]            neg_in;
   logic [1:0]            neg_ff;
   logic [DW-1:0]         den_in;
   logic [DW-1:0]         den_ff;

   // stage a: intrinsic products, depth test, cam saturation
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         fa_in[k] = $signed({1'b0, cfg.focal[k]}) * $signed(cam[k]);
         cz_in[k] = $signed({1'b0, cfg.princ[k]}) * $signed(cam[2]);
      end
      side_a_in.front = $signed(cam[2]) > $signed({{(CW-MDW){1'b0}}, cfg.min_depth});
      side_a_in.cam_x = sat_cam($signed(cam[0]));
      side_a_in.cam_y = sat_cam($signed(cam[1]));
      side_a_in.cam_z = sat_cam($signed(cam[2]));
   end

   // stage b: rounding numerator 2*num+16z and divisor 32z
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         num[k] = ((NW'(fa_ff[k]) + NW'(cz_ff[k])) <<< 1) + (NW'(z_ff) <<< 4);
         neg_in[k] = num[k][NW-1];
         m_in[k] = neg_in[k] ? MW'(~num[k]) : MW'(num[k]);
      end
      den_in = DW'({z_ff, 5'b0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fa_ff     <= fa_in;
         cz_ff     <= cz_in;
         z_ff      <= $signed(cam[2]);
         side_a_ff <= side_a_in;
         m_ff      <= m_in;
         neg_ff    <= neg_in;
         den_ff    <= den_in;
         side_b_ff <= side_a_ff;
      end
   end

   assign m_u   = m_ff[0];
   assign m_v   = m_ff[1];
   assign neg_u = neg_ff[0];
   assign neg_v = neg_ff[1];
   assign den   = den_ff;
   assign side  = side_b_ff;
endmodule
`default_nettype wire

// ----- sv/lpp_div.sv -----
`default_nettype none
module lpp_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [lpp_pkg::MW-1:0]    m,
   input  logic [lpp_pkg::DW-1:0]    d,
   input  logic                      neg,
   output logic [lpp_pkg::QB-1:0]    q,
   output logic                      ovf,
   output logic                      neg_o
);
   import lpp_pkg::*;

   logic [MW-1:0] rem_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [DW-1:0] d_ff   [QB+1];
   logic          ng_ff  [QB+1];
   logic          ov_ff  [QB+1];

   // stage 0: quotient at or above full scale saturates
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= m;
         q_ff[0]   <= '0;
         d_ff[0]   <= d;
         ng_ff[0]  <= neg;
         ov_ff[0]  <= m >= {d, {QB{1'b0}}};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int S = QB - 1 - k;
      logic [MW-1:0] trial;
      logic          hit;
      logic [MW-1:0] rem_in;
      logic [QB-1:0] q_in;

      assign trial  = MW'(d_ff[k]) << S;
      assign hit    = rem_ff[k] >= trial;
      assign rem_in = hit ? rem_ff[k] - trial : rem_ff[k];
      assign q_in   = hit ? q_ff[k] | (QB'(1) << S) : q_ff[k];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            q_ff[k+1]   <= q_in;
            d_ff[k+1]   <= d_ff[k];
            ng_ff[k+1]  <= ng_ff[k];
            ov_ff[k+1]  <= ov_ff[k];
         end
      end
   end

   assign q     = q_ff[QB];
   assign ovf   = ov_ff[QB];
   assign neg_o = ng_ff[QB];
endmodule
`default_nettype wire

// ----- sv/lidar_point_to_pixel_projection_unit.sv -----
`default_nettype none
// channel   dir   word
// req_chan  in    point_x, point_y, point_z (signed q8.16)
// rsp_chan  out   in_front, cam_x/y/z (q8.16), pixel_u/v (q16.4)
// csr_*     in    write enable, register index, 63-bit write data
//
// one word per cycle unless rsp_chan stalls, 25 register stages
// u and v each pass through a 19-step restoring divider
// reset clears valid bits and loads the register defaults
// a stall on rsp_chan freezes every stage, req_chan.ready drops with it
module lidar_point_to_pixel_projection_unit (
   input  logic                          clock,
   input  logic                          reset,
   lpp_req_if.sink                       req_chan,
   lpp_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [lpp_pkg::RIW-1:0]       csr_index,
   input  logic [lpp_pkg::CSRW-1:0]      csr_wdata
);
   import lpp_pkg::*;

   logic [3*RW-1:0]   rot_x_ff;
   logic [3*RW-1:0]   rot_y_ff;
   logic [3*RW-1:0]   rot_z_ff;
   logic [3*TW-1:0]   trans_ff;
   logic [2*FW-1:0]   focal_ff;
   logic [2*FW-1:0]   princ_ff;
   logic [MDW-1:0]    min_depth_ff;
   cfg_type           cfg;

   logic              pipe_en;
   logic [TOTAL-1:0]  vld_ff;
   logic [2:0][CW-1:0] cam;
   logic [MW-1:0]     m_u;
   logic [MW-1:0]     m_v;
   logic              neg_u;
   logic              neg_v;
   logic [DW-1:0]     den;
   side_type          side_p;
   side_type          side_ff [DIV_LAT];
   logic [QB-1:0]     q_u;
   logic [QB-1:0]     q_v;
   logic              ovf_u;
   logic              ovf_v;
   logic              ng_u;
   logic              ng_v;
   side_type          out_side_ff;
   logic [PXW-1:0]    pu_in;
   logic [PXW-1:0]    pv_in;
   logic [PXW-1:0]    pu_ff;
   logic [PXW-1:0]    pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff     <= ROT_X_RST;
         rot_y_ff     <= ROT_Y_RST;
         rot_z_ff     <= ROT_Z_RST;
         trans_ff     <= TRANS_RST;
         focal_ff     <= FOCAL_RST;
         princ_ff     <= PRINC_RST;
         min_depth_ff <= MIN_DEPTH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROT_X:       rot_x_ff     <= csr_wdata[3*RW-1:0];
            REG_ROT_Y:       rot_y_ff     <= csr_wdata[3*RW-1:0];
            REG_ROT_Z:       rot_z_ff     <= csr_wdata[3*RW-1:0];
            REG_TRANSLATION: trans_ff     <= csr_wdata[3*TW-1:0];
            REG_FOCAL:       focal_ff     <= csr_wdata[2*FW-1:0];
            REG_PRINCIPAL:   princ_ff     <= csr_wdata[2*FW-1:0];
            REG_MIN_DEPTH:   min_depth_ff <= csr_wdata[MDW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.rot       = {rot_z_ff, rot_y_ff, rot_x_ff};
   assign cfg.trans     = trans_ff;
   assign cfg.focal     = focal_ff;
   assign cfg.princ     = princ_ff;
   assign cfg.min_depth = min_depth_ff;

   assign pipe_en        = !vld_ff[TOTAL-1] || rsp_chan.ready;
   assign req_chan.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_chan.valid};
      end
   end

   lpp_transform u_transform (
      .clock   (clock),
      .en      (pipe_en),
      .cfg     (cfg),
      .point_x (req_chan.point_x),
      .point_y (req_chan.point_y),
      .point_z (req_chan.point_z),
      .cam     (cam)
   );

   lpp_project u_project (
      .clock (clock),
      .en    (pipe_en),
      .cfg   (cfg),
      .cam   (cam),
      .m_u   (m_u),
      .m_v   (m_v),
      .neg_u (neg_u),
      .neg_v (neg_v),
      .den   (den),
      .side  (side_p)
   );

   lpp_div u_div_u (
      .clock (clock),
      .en    (pipe_en),
      .m     (m_u),
      .d     (den),
      .neg   (neg_u),
      .q     (q_u),
      .ovf   (ovf_u),
      .neg_o (ng_u)
   );

   lpp_div u_div_v (
      .clock (clock),
      .en    (pipe_en),
      .m     (m_v),
      .d     (den),
      .neg   (neg_v),
      .q     (q_v),
      .ovf   (ovf_v),
      .neg_o (ng_v)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[0] <= side_p;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // skipped points report a zero pixel
   always_comb begin
      pu_in = '0;
      pv_in = '0;
      if (side_ff[DIV_LAT-1].front) begin
         pu_in = fmt_pixel(q_u, ovf_u, ng_u);
         pv_in = fmt_pixel(q_v, ovf_v, ng_v);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_side_ff <= side_ff[DIV_LAT-1];
         pu_ff       <= pu_in;
         pv_ff       <= pv_in;
      end
   end

   assign rsp_chan.valid    = vld_ff[TOTAL-1];
   assign rsp_chan.in_front = out_side_ff.front;
   assign rsp_chan.cam_x    = $signed(out_side_ff.cam_x);
   assign rsp_chan.cam_y    = $signed(out_side_ff.cam_y);
   assign rsp_chan.cam_z    = $signed(out_side_ff.cam_z);
   assign rsp_chan.pixel_u  = $signed(pu_ff);
   assign rsp_chan.pixel_v  = $signed(pv_ff);

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.in_front |-> rsp_chan.pixel_u == '0 && rsp_chan.pixel_v == '0)
      else $error("skipped word with nonzero pixel");

   a_front_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.in_front |-> rsp_chan.cam_z > 0)
      else $error("in-front word with nonpositive depth");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
endmodule
`default_nettype wire
